// ----- rtl/mei_pkg.sv -----
// Shared types and constants for the Mandelbrot escape iteration unit.
package mei_pkg;

  localparam int IN_W       = 48;
  localparam int CNT_W      = 17;
  localparam int MAG_W      = 64;
  localparam int MAXIT_W    = 16;
  localparam int RAD_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    CLS_ESCAPED  = 2'd0,
    CLS_INSIDE   = 2'd1,
    CLS_PERIODIC = 2'd2,
    CLS_LIMIT    = 2'd3
  } cls_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_RAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_EN   = 2'd2;

endpackage

// ----- rtl/mei_channels.sv -----
// Valid/ready channel interfaces for points in and results out.
interface mei_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mei_pkg::IN_W-1:0]     c_real;
  logic signed [mei_pkg::IN_W-1:0]     c_imag;

  modport source (output valid, c_real, c_imag, input ready);
  modport sink (input valid, c_real, c_imag, output ready);
endinterface

interface mei_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_class;
  logic [mei_pkg::CNT_W-1:0]     escape_count;
  logic [mei_pkg::MAG_W-1:0]     final_mag_sq;

  modport source (output valid, result_class, escape_count, final_mag_sq, input ready);
  modport sink (input valid, result_class, escape_count, final_mag_sq, output ready);
endinterface

// ----- rtl/mandelbrot_escape_iteration_unit.sv -----
// Mandelbrot escape iteration unit: one shared 32x32 multiplier under a sequencer.
//
// Usage: a point c (c_real, c_imag, signed, FRAC_BITS fraction bits) is taken on
// in_ch when valid and ready are both high; one result beat leaves on out_ch.
// The block holds one point at a time; in_ch.ready is high only while idle.
// Every 64x64 product runs on one 32x32 multiplier as four partial products.
// Each point first runs the cardioid and bulb tests (the cardioid test uses a
// one-bit-per-cycle square root), then iterates with checkpoints for the
// periodicity test, and runs two extra iterations after an escape.
// The result sits in an output register: the next point is accepted while an
// earlier result still waits for out_ch.ready. If the receiver stalls and a
// second result is done, the block holds it until the output register frees.
// Configuration (cfg_we, cfg_idx, cfg_wdata) must be written only while idle;
// the block does not enforce it. Reset (rst_n low, synchronous) returns to
// idle, drops out_ch.valid and loads max_iterations 1000, escape_radius_sq 4,
// periodicity_enable 1.
module mandelbrot_escape_iteration_unit #(
  parameter int FRAC_BITS = 44,
  parameter int ITER_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mei_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mei_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mei_in_if.sink                             in_ch,
  mei_out_if.source                          out_ch
);

  localparam logic signed [63:0] SMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SMAX65  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] NMAX65  = -SMAX65;
  localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] QUARTER = ONE >>> 2;
  localparam logic [127:0]       LIM2    = 128'd1 << (2 * FRAC_BITS - 4);
  localparam int                 NCW     = (ITER_BITS > mei_pkg::CNT_W) ?
                                           ITER_BITS : mei_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_POST, ST_SQRT, ST_CKPT, ST_CHK, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_CARD_D, OP_CARD_I, OP_CARD_Q, OP_BULB_D, OP_BULB_I, OP_SQ_R, OP_SQ_I, OP_CROSS
  } op_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > SMAX65) return SMAX;
    if (s < NMAX65) return -SMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > SMAX65) return SMAX;
    if (s < NMAX65) return -SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_fix(input logic [127:0] v, input logic neg);
    logic signed [63:0] m;
    m = (|v[127:63]) ? SMAX : {1'b0, v[62:0]};
    return neg ? -m : m;
  endfunction

  function automatic logic [63:0] mag_sq(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
    return (a == SMAX || b == SMAX) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(a) + 64'(b);
  endfunction

  // control
  state_t                         state_r, state_nxt;
  op_t                            op_r, op_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           esc_r, esc_nxt;
  logic [mei_pkg::MAXIT_W-1:0]    max_iter_r, max_iter_nxt;
  logic [mei_pkg::RAD_W-1:0]      esc_rad_r, esc_rad_nxt;
  logic                           per_en_r, per_en_nxt;

  // payload
  logic signed [63:0]  cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [63:0]  zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [63:0]  sr_r, sr_nxt, si_r, si_nxt;
  logic signed [63:0]  zr2_r, zr2_nxt, zi2_r, zi2_nxt;
  logic signed [63:0]  q_r, q_nxt;
  logic [63:0]         mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic                neg_r, neg_nxt;
  logic [2:0]          mc_r, mc_nxt;
  logic [63:0]         pp_r, pp_nxt;
  logic [1:0]          pp_sh_r, pp_sh_nxt;
  logic [127:0]        acc_r, acc_nxt;
  logic [127:0]        sum_r, sum_nxt;
  logic [127:0]        sq_x_r, sq_x_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [5:0]          sq_cnt_r, sq_cnt_nxt;
  logic [ITER_BITS-1:0] n_r, n_nxt;
  logic [ITER_BITS:0]  lim_r, lim_nxt;
  logic [1:0]          ext_r, ext_nxt;
  logic [1:0]          pend_cls_r, pend_cls_nxt, out_cls_r, out_cls_nxt;
  logic [mei_pkg::CNT_W-1:0] pend_cnt_r, pend_cnt_nxt, out_cnt_r, out_cnt_nxt;
  logic [63:0]         pend_mag_r, pend_mag_nxt, out_mag_r, out_mag_nxt;

  // shared datapath terms
  logic [ITER_BITS:0]  maxit_ext;
  logic [127:0]        thr_wide;
  logic [63:0]         thr;
  logic [31:0]         a_half, b_half;
  logic [127:0]        acc_add;
  logic signed [63:0]  fix_f, fix_f1;
  logic [127:0]        sq_t;
  logic [NCW-1:0]      n_plus3;

  assign maxit_ext = {1'b0, ITER_BITS'(max_iter_r)};
  assign thr_wide  = 128'(esc_rad_r) << FRAC_BITS;
  assign thr       = (|thr_wide[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : thr_wide[63:0];
  assign a_half    = mc_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_half    = mc_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign fix_f     = sat_fix(acc_r >> FRAC_BITS, neg_r);
  assign fix_f1    = sat_fix(acc_r >> (FRAC_BITS - 1), neg_r);
  assign sq_t      = sq_res_r + sq_bit_r;
  assign n_plus3   = NCW'(n_r) + NCW'(3);

  always_comb begin
    case (pp_sh_r)
      2'd0:    acc_add = acc_r + {64'b0, pp_r};
      2'd1:    acc_add = acc_r + {32'b0, pp_r, 32'b0};
      default: acc_add = acc_r + {pp_r, 64'b0};
    endcase
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_class = out_cls_r;
  assign out_ch.escape_count = out_cnt_r;
  assign out_ch.final_mag_sq = out_mag_r;

  always_comb begin
    logic               mst;
    logic [63:0]        ma, mb;
    logic               mn;
    op_t                mo;
    logic               fin;
    logic [1:0]         fcls;
    logic signed [63:0] rhs, zrn, zin, qs;
    logic [127:0]       s;
    logic [63:0]        mag;
    logic [ITER_BITS:0] dbl;
    logic [127:0]       res_new;

    mst = 1'b0; ma = '0; mb = '0; mn = 1'b0; mo = OP_CARD_D;
    fin = 1'b0; fcls = mei_pkg::CLS_LIMIT;
    rhs = '0; zrn = '0; zin = '0; qs = '0; s = '0; mag = '0; dbl = '0; res_new = '0;

    state_nxt = state_r;     op_nxt = op_r;         esc_nxt = esc_r;
    max_iter_nxt = max_iter_r; esc_rad_nxt = esc_rad_r; per_en_nxt = per_en_r;
    cr_nxt = cr_r; ci_nxt = ci_r; zr_nxt = zr_r; zi_nxt = zi_r;
    sr_nxt = sr_r; si_nxt = si_r; zr2_nxt = zr2_r; zi2_nxt = zi2_r; q_nxt = q_r;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r; neg_nxt = neg_r;
    mc_nxt = mc_r; pp_nxt = pp_r; pp_sh_nxt = pp_sh_r; acc_nxt = acc_r; sum_nxt = sum_r;
    sq_x_nxt = sq_x_r; sq_res_nxt = sq_res_r; sq_bit_nxt = sq_bit_r; sq_cnt_nxt = sq_cnt_r;
    n_nxt = n_r; lim_nxt = lim_r; ext_nxt = ext_r;
    pend_cls_nxt = pend_cls_r; pend_cnt_nxt = pend_cnt_r; pend_mag_nxt = pend_mag_r;
    out_cls_nxt = out_cls_r; out_cnt_nxt = out_cnt_r; out_mag_nxt = out_mag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (cfg_we) begin
      case (cfg_idx)
        mei_pkg::CFG_MAX_ITER: max_iter_nxt = cfg_wdata[mei_pkg::MAXIT_W-1:0];
        mei_pkg::CFG_ESC_RAD:  esc_rad_nxt  = cfg_wdata;
        mei_pkg::CFG_PER_EN:   per_en_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cr_nxt = 64'(in_ch.c_real);
          ci_nxt = 64'(in_ch.c_imag);
          mst = 1'b1; mo = OP_CARD_D;
          ma = umag(64'(in_ch.c_real) - QUARTER);
          mb = ma;
        end
      end

      ST_MUL: begin
        if (mc_r != 3'd4) begin
          pp_nxt    = a_half * b_half;
          pp_sh_nxt = 2'(mc_r[1]) + 2'(mc_r[0]);
        end
        if (mc_r != 3'd0) acc_nxt = acc_add;
        mc_nxt = mc_r + 3'd1;
        if (mc_r == 3'd4) state_nxt = ST_POST;
      end

      ST_POST: begin
        case (op_r)
          OP_CARD_D: begin
            sum_nxt = acc_r;
            mst = 1'b1; mo = OP_CARD_I; ma = umag(ci_r); mb = ma;
          end
          OP_CARD_I: begin
            sq_x_nxt   = sum_r + acc_r;
            sq_res_nxt = '0;
            sq_bit_nxt = 128'd1 << 126;
            sq_cnt_nxt = '0;
            state_nxt  = ST_SQRT;
          end
          OP_CARD_Q: begin
            rhs = sat_add(sat_sub(q_r, fix_f1), QUARTER);
            if (cr_r < rhs) begin
              fin = 1'b1; fcls = mei_pkg::CLS_INSIDE;
            end else begin
              mst = 1'b1; mo = OP_BULB_D; ma = umag(cr_r + ONE); mb = ma;
            end
          end
          OP_BULB_D: begin
            sum_nxt = acc_r;
            mst = 1'b1; mo = OP_BULB_I; ma = umag(ci_r); mb = ma;
          end
          OP_BULB_I: begin
            s = sum_r + acc_r;
            if (s < LIM2) begin
              fin = 1'b1; fcls = mei_pkg::CLS_INSIDE;
            end else begin
              zr_nxt = cr_r; zi_nxt = ci_r;
              n_nxt = '0; lim_nxt = (ITER_BITS + 1)'(8);
              esc_nxt = 1'b0;
              state_nxt = ST_CKPT;
            end
          end
          OP_SQ_R: begin
            zr2_nxt = fix_f;
            mst = 1'b1; mo = OP_SQ_I; ma = umag(zi_r); mb = ma;
          end
          OP_SQ_I: begin
            zi2_nxt = fix_f;
            mag = mag_sq(zr2_r, fix_f);
            if (esc_r && ext_r == 2'd2) begin
              fin = 1'b1; fcls = mei_pkg::CLS_ESCAPED;
            end else begin
              if (!esc_r && mag > thr) begin
                esc_nxt = 1'b1; ext_nxt = 2'd0;
              end
              mst = 1'b1; mo = OP_CROSS; ma = umag(zr_r); mb = umag(zi_r);
              mn = zr_r[63] ^ zi_r[63];
            end
          end
          default: begin  // OP_CROSS
            zin = sat_add(fix_f1, ci_r);
            zrn = sat_add(sat_sub(zr2_r, zi2_r), cr_r);
            zr_nxt = zrn; zi_nxt = zin;
            if (esc_r) begin
              ext_nxt = ext_r + 2'd1;
              mst = 1'b1; mo = OP_SQ_R; ma = umag(zrn); mb = ma;
            end else if (per_en_r && zrn == sr_r && zin == si_r) begin
              fin = 1'b1; fcls = mei_pkg::CLS_PERIODIC;
            end else begin
              n_nxt = n_r + 1'b1;
              state_nxt = ST_CHK;
            end
          end
        endcase
      end

      ST_SQRT: begin
        if (sq_x_r >= sq_t) begin
          sq_x_nxt = sq_x_r - sq_t;
          res_new  = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          res_new  = sq_res_r >> 1;
        end
        sq_res_nxt = res_new;
        sq_bit_nxt = sq_bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'd63) begin
          qs = (res_new[63]) ? SMAX : res_new[63:0];
          q_nxt = qs;
          mst = 1'b1; mo = OP_CARD_Q; ma = qs; mb = qs;
        end
      end

      ST_CKPT: begin
        // latch checkpoint and widen the window
        sr_nxt = zr_r; si_nxt = zi_r;
        dbl = {lim_r[ITER_BITS-1:0], 1'b0};
        lim_nxt = (dbl > maxit_ext) ? maxit_ext : dbl;
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if ({1'b0, n_r} < lim_r) begin
          mst = 1'b1; mo = OP_SQ_R; ma = umag(zr_r); mb = ma;
        end else if (lim_r == maxit_ext) begin
          fin = 1'b1; fcls = mei_pkg::CLS_LIMIT;
        end else begin
          state_nxt = ST_CKPT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cls_nxt = pend_cls_r;
          out_cnt_nxt = pend_cnt_r;
          out_mag_nxt = pend_mag_r;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (mst) begin
      mul_a_nxt = ma; mul_b_nxt = mb; neg_nxt = mn; op_nxt = mo;
      mc_nxt = '0; acc_nxt = '0;
      state_nxt = ST_MUL;
    end

    if (fin) begin
      pend_cls_nxt = fcls;
      if (fcls == mei_pkg::CLS_ESCAPED) begin
        pend_cnt_nxt = n_plus3[mei_pkg::CNT_W-1:0];
        pend_mag_nxt = mag;
      end else begin
        pend_cnt_nxt = '0;
        pend_mag_nxt = '0;
      end
      state_nxt = ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      esc_r       <= 1'b0;
      op_r        <= OP_CARD_D;
      max_iter_r  <= mei_pkg::MAXIT_W'(1000);
      esc_rad_r   <= mei_pkg::RAD_W'(4);
      per_en_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      esc_r       <= esc_nxt;
      op_r        <= op_nxt;
      max_iter_r  <= max_iter_nxt;
      esc_rad_r   <= esc_rad_nxt;
      per_en_r    <= per_en_nxt;
    end
    cr_r <= cr_nxt;   ci_r <= ci_nxt;   zr_r <= zr_nxt;   zi_r <= zi_nxt;
    sr_r <= sr_nxt;   si_r <= si_nxt;   zr2_r <= zr2_nxt; zi2_r <= zi2_nxt;
    q_r <= q_nxt;     mul_a_r <= mul_a_nxt; mul_b_r <= mul_b_nxt; neg_r <= neg_nxt;
    mc_r <= mc_nxt;   pp_r <= pp_nxt;   pp_sh_r <= pp_sh_nxt; acc_r <= acc_nxt;
    sum_r <= sum_nxt; sq_x_r <= sq_x_nxt; sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt; sq_cnt_r <= sq_cnt_nxt;
    n_r <= n_nxt;     lim_r <= lim_nxt; ext_r <= ext_nxt;
    pend_cls_r <= pend_cls_nxt; pend_cnt_r <= pend_cnt_nxt; pend_mag_r <= pend_mag_nxt;
    out_cls_r <= out_cls_nxt;   out_cnt_r <= out_cnt_nxt;   out_mag_r <= out_mag_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted a point but stayed ready");

  a_inside_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_class != mei_pkg::CLS_ESCAPED |->
      out_ch.escape_count == '0 && out_ch.final_mag_sq == '0)
    else $error("non-escape result carries count or magnitude");

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHK |-> {1'b0, n_r} <= lim_r)
    else $error("iteration count ran past checkpoint window");

  a_extra_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r && state_r == ST_POST |-> ext_r != 2'd3)
    else $error("too many extra iterations after escape");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == ST_EMIT)
    else $error("result appeared outside emit step");

endmodule
